// ===== design/wfm_pkg.sv =====
// Shared constants, operation codes and control types of the waveform meter.
package wfm_pkg;

  // Default ADC code width.
  localparam int SAMPLE_BITS_DEF = 10;

  // Batch counters saturate at their 17-bit maximum.
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register and result widths.
  localparam int RATE_W   = 20;
  localparam int FS_W     = 13;
  localparam int PERIOD_W = 20;
  localparam int DUTY_W   = 7;

  // Configuration register indexes.
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 1'd0;
  localparam logic [IDX_W-1:0] REG_FULL_SCALE  = 1'd1;

  // Register reset values.
  localparam logic [RATE_W-1:0] RATE_RESET = 20'd125000;
  localparam logic [FS_W-1:0]   FS_RESET   = 13'd3000;

  // Arithmetic constants.
  localparam logic [RATE_W-1:0] ONE_MILLION = 20'd1000000;
  localparam logic [DUTY_W-1:0] DUTY_SCALE  = 7'd100;

  // Shared divider operand widths.
  localparam int DVD_W = 24;
  localparam int DVS_W = 20;

  // Division operations run by the sequencer.
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_MEAN   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_PERIOD = 2'd2;
  localparam logic [OP_W-1:0] OP_DUTY   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            accept;
    logic            load_amp;
    logic            div_start;
    logic [OP_W-1:0] div_sel;
    logic            clear;
  } wfm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic enough;
    logic quot_zero;
  } wfm_status_t;

  // Saturating increment of a batch counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== design/waveform_freq_duty_amplitude_meter.sv =====
// Top level of the waveform frequency, duty and amplitude meter.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  sample in | start, busy        | sample, last_sample
//  config    | wr_en              | wr_index, wr_data
//  result    | done (one cycle)   | frequency_hz, period_us, amplitude_mv,
//            |                    | duty_percent, measure_error
//
// A sample word is taken with start, so a batch streams at one per clock.
// The last word of a batch starts the report: the amplitude is loaded, then
// the shared one-bit-per-cycle divider runs for one to four quotients (mean
// interval, frequency, period, duty), then the result strobe follows. Reset
// is synchronous; it returns the peaks and threshold to mid-scale and clears
// the counters. The result strobe cannot be held off.
module waveform_freq_duty_amplitude_meter import wfm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last_sample,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_index,
  input  logic [RATE_W-1:0]      wr_data,
  output logic                   done,
  output logic [RATE_W-1:0]      frequency_hz,
  output logic [PERIOD_W-1:0]    period_us,
  output logic [FS_W-1:0]        amplitude_mv,
  output logic [DUTY_W-1:0]      duty_percent,
  output logic                   measure_error
);

  wfm_cmd_t    cmd;
  wfm_status_t status;

  wfm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_sample (last_sample),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done)
  );

  wfm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .sample        (sample),
    .cmd           (cmd),
    .status        (status),
    .frequency_hz  (frequency_hz),
    .period_us     (period_us),
    .amplitude_mv  (amplitude_mv),
    .duty_percent  (duty_percent),
    .measure_error (measure_error)
  );

endmodule

// ===== design/wfm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module wfm_div import wfm_pkg::*; #(
  parameter int DW = DVD_W,
  parameter int SW = DVS_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic [DW-1:0] dvd;
  logic [SW-1:0] rem;
  logic [SW-1:0] dvs;
  logic [CW-1:0] count;
  logic          running;

  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          fits;
  logic [SW-1:0] rem_next;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem, dvd[DW-1]};
    diff     = trial - {1'b0, dvs};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? diff[SW-1:0] : trial[SW-1:0];
  end

  // Step control: one step per dividend bit after start, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CW'(DW - 1);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder registers; the dividend fills with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[DW-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = dvd;

endmodule

// ===== design/wfm_ctrl.sv =====
// Controller: sample acceptance and the division sequence of the report.
module wfm_ctrl import wfm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        last_sample,
  input  wfm_status_t status,
  output wfm_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_AMP  = 3'd1;
  localparam logic [ST_W-1:0] ST_GO   = 3'd2;
  localparam logic [ST_W-1:0] ST_WAIT = 3'd3;
  localparam logic [ST_W-1:0] ST_EMIT = 3'd4;

  logic [ST_W-1:0] state;
  logic [ST_W-1:0] state_next;
  logic [OP_W-1:0] op;
  logic [OP_W-1:0] op_next;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    op_next     = op;
    cmd         = '0;
    cmd.div_sel = op;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (last_sample) begin
            state_next = ST_AMP;
          end
        end
      end
      ST_AMP: begin
        cmd.load_amp = 1'b1;
        op_next      = status.enough ? OP_MEAN : OP_DUTY;
        state_next   = ST_GO;
      end
      ST_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.div_done) begin
          state_next = ST_GO;
          case (op)
            OP_MEAN:   op_next = status.quot_zero ? OP_DUTY : OP_FREQ;
            OP_FREQ:   op_next = status.quot_zero ? OP_DUTY : OP_PERIOD;
            OP_PERIOD: op_next = OP_DUTY;
            OP_DUTY:   state_next = ST_EMIT;
            default:   state_next = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_MEAN;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_EMIT);

endmodule

// ===== design/wfm_datapath.sv =====
// Datapath: configuration, per-sample tracking, result registers and divider.
module wfm_datapath import wfm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_index,
  input  logic [RATE_W-1:0]      wr_data,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  wfm_cmd_t               cmd,
  output wfm_status_t            status,
  output logic [RATE_W-1:0]      frequency_hz,
  output logic [PERIOD_W-1:0]    period_us,
  output logic [FS_W-1:0]        amplitude_mv,
  output logic [DUTY_W-1:0]      duty_percent,
  output logic                   measure_error
);

  localparam int PK_W = SAMPLE_BITS + 1;
  localparam logic [PK_W-1:0] CODE_SPAN = PK_W'(2 ** SAMPLE_BITS);
  localparam logic [PK_W-1:0] CODE_MID  = PK_W'(2 ** (SAMPLE_BITS - 1));

  logic [RATE_W-1:0] sample_rate_hz;
  logic [FS_W-1:0]   full_scale_mv;

  logic [PK_W-1:0]  peak_high;
  logic [PK_W-1:0]  peak_low;
  logic [PK_W-1:0]  threshold_level;
  logic             prev_above;
  logic [CNT_W-1:0] batch_count;
  logic [CNT_W-1:0] above_count;
  logic [CNT_W-1:0] crossing_position;
  logic [CNT_W-1:0] crossing_total;
  logic [CNT_W-1:0] interval_sum;
  logic [CNT_W-1:0] mean_interval;

  logic [PK_W-1:0]  sample_ext;
  logic [CNT_W-1:0] batch_count_next;
  logic [PK_W-1:0]  peak_high_next;
  logic [PK_W-1:0]  peak_low_next;
  logic [PK_W:0]    peak_sum;
  logic             above;
  logic             falling;
  logic [CNT_W-1:0] gap;
  logic [CNT_W:0]   gap_sum;

  logic [PK_W-1:0]      span;
  logic [PK_W+FS_W-1:0] amp_prod;

  logic [DVD_W-1:0] duty_num;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quotient;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz <= RATE_RESET;
      full_scale_mv  <= FS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SAMPLE_RATE: sample_rate_hz <= wr_data;
        REG_FULL_SCALE:  full_scale_mv  <= wr_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-sample peaks, threshold compare and crossing interval.
  always_comb begin
    sample_ext       = {1'b0, sample};
    batch_count_next = sat_inc(batch_count);
    peak_high_next   = (sample_ext > peak_high) ? sample_ext : peak_high;
    peak_low_next    = (sample_ext < peak_low) ? sample_ext : peak_low;
    peak_sum         = {1'b0, peak_high_next} + {1'b0, peak_low_next};
    above            = sample_ext > threshold_level;
    falling          = prev_above && !above;
    gap              = batch_count_next - crossing_position;
    gap_sum          = {1'b0, interval_sum} + {1'b0, gap};
  end

  // Batch tracking state; counters cleared and peaks reset after each report.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_high         <= CODE_MID;
      peak_low          <= CODE_MID;
      threshold_level   <= CODE_MID;
      prev_above        <= 1'b0;
      batch_count       <= '0;
      above_count       <= '0;
      crossing_position <= '0;
      crossing_total    <= '0;
      interval_sum      <= '0;
    end else if (cmd.clear) begin
      peak_high      <= '0;
      peak_low       <= CODE_SPAN;
      batch_count    <= '0;
      above_count    <= '0;
      crossing_total <= '0;
      interval_sum   <= '0;
    end else if (cmd.accept) begin
      batch_count     <= batch_count_next;
      peak_high       <= peak_high_next;
      peak_low        <= peak_low_next;
      threshold_level <= peak_sum[PK_W:1];
      prev_above      <= above;
      if (above) begin
        above_count <= sat_inc(above_count);
      end
      if (falling) begin
        if (crossing_total != '0) begin
          interval_sum <= gap_sum[CNT_W] ? CNT_MAX : gap_sum[CNT_W-1:0];
        end
        crossing_position <= batch_count_next;
        crossing_total    <= sat_inc(crossing_total);
      end
    end
  end

  // Peak-to-peak span scaled to millivolts.
  always_comb begin
    span     = (peak_high >= peak_low) ? (peak_high - peak_low) : '0;
    amp_prod = (PK_W + FS_W)'(span) * (PK_W + FS_W)'(full_scale_mv);
  end

  // Operand selection for the shared divider.
  always_comb begin
    duty_num = DVD_W'(above_count) * DVD_W'(DUTY_SCALE);
    case (cmd.div_sel)
      OP_MEAN: begin
        div_dividend = DVD_W'(interval_sum);
        div_divisor  = DVS_W'(crossing_total - 1'b1);
      end
      OP_FREQ: begin
        div_dividend = DVD_W'(sample_rate_hz);
        div_divisor  = DVS_W'(mean_interval);
      end
      OP_PERIOD: begin
        div_dividend = DVD_W'(ONE_MILLION);
        div_divisor  = DVS_W'(frequency_hz);
      end
      OP_DUTY: begin
        div_dividend = duty_num;
        div_divisor  = DVS_W'(batch_count);
      end
      default: begin
        div_dividend = duty_num;
        div_divisor  = DVS_W'(batch_count);
      end
    endcase
  end

  wfm_div #(
    .DW (DVD_W),
    .SW (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Result registers, preset with the amplitude, filled as divisions finish.
  always_ff @(posedge clk) begin
    if (cmd.load_amp) begin
      amplitude_mv  <= FS_W'(amp_prod >> SAMPLE_BITS);
      frequency_hz  <= '0;
      period_us     <= '0;
      measure_error <= 1'b1;
    end else if (div_done) begin
      case (cmd.div_sel)
        OP_MEAN:   mean_interval <= div_quotient[CNT_W-1:0];
        OP_FREQ:   frequency_hz  <= div_quotient[RATE_W-1:0];
        OP_PERIOD: begin
          period_us     <= div_quotient[PERIOD_W-1:0];
          measure_error <= 1'b0;
        end
        OP_DUTY:   duty_percent  <= div_quotient[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Status back to the controller.
  always_comb begin
    status.div_done  = div_done;
    status.enough    = crossing_total >= CNT_W'(2);
    status.quot_zero = (div_quotient == '0);
  end

endmodule

// ===== design/wfm_checker.sv =====
// Port-level checks of the waveform meter and their binding to the top level.
module wfm_checker import wfm_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   last_sample,
  input logic                   done,
  input logic [RATE_W-1:0]      frequency_hz,
  input logic [DUTY_W-1:0]      duty_percent,
  input logic                   measure_error
);

  // A result only appears while a report is in progress.
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a report");

  // The last word of a batch starts a report; any other word does not.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy == $past(last_sample)))
    else $error("busy does not follow the batch end");

  // Each report yields exactly one result cycle.
  assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  // Duty is a percentage.
  assert property (@(posedge clk) disable iff (rst) done |-> duty_percent <= DUTY_SCALE)
    else $error("duty above 100 percent");

  // The error flag and a zero frequency go together.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (measure_error == (frequency_hz == '0)))
    else $error("error flag disagrees with frequency");

endmodule

bind waveform_freq_duty_amplitude_meter wfm_checker u_wfm_checker (.*);
